// ----- sv/mfd_pkg.sv -----
package mfd_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 7;
    localparam int TAP_CFG_W  = 8;
    localparam int DEC_CFG_W  = 4;
    localparam int PHASE_W    = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 2'd1;

    // register reset values and limits
    localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RST = 8'd33;
    localparam logic [DEC_CFG_W-1:0] DECIM_RST     = 4'd4;
    localparam logic [DEC_CFG_W-1:0] DEC_MAX       = 4'd8;

    // results per item
    localparam int RES_W     = 5;
    localparam int RES_LIMIT = 16;

    // item kinds
    localparam logic KIND_COEF = 1'b1;

    // rounding and saturation of sums of Q3.29 products to Q1.15
    localparam int ROUND_SHIFT = 14;
    localparam int ROUND_HALF  = 8192;
    localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic coef_we;
        logic adv;
        logic adv_zero;
        logic acc_clr;
        logic issue;
        logic round;
        logic push;
        logic push_last;
        logic frame_clr;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/mfd_in_if.sv -----
interface mfd_in_if;
    import mfd_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [SAMPLE_W-1:0]   sample_i;
    logic signed [SAMPLE_W-1:0]   sample_q;
    logic                         frame_end;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0]     coef_value;

    modport source (
        output valid, kind, sample_i, sample_q, frame_end, coef_index, coef_value,
        input  ready
    );

    modport sink (
        input  valid, kind, sample_i, sample_q, frame_end, coef_index, coef_value,
        output ready
    );

endinterface

// ----- sv/mfd_out_if.sv -----
interface mfd_out_if;
    import mfd_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_W-1:0]   out_i;
    logic signed [SAMPLE_W-1:0]   out_q;
    logic                         clipped;
    logic                         last_of_run;

    modport source (
        output valid, out_i, out_q, clipped, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, out_i, out_q, clipped, last_of_run,
        output ready
    );

endinterface

// ----- sv/mfd_ctrl.sv -----
module mfd_ctrl #(
    parameter int MAX_TAPS = 128,
    parameter int TAP_AW   = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_kind,
    input  logic                              i_in_frame_end,
    output logic                              o_in_ready,
    output mfd_pkg::t_dp_cmd                  o_cmd,
    output logic [TAP_AW-1:0]                 o_tap,
    input  mfd_pkg::t_dp_status               i_status
);
    import mfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int TC_W  = (CNT_W > TAP_CFG_W) ? CNT_W : TAP_CFG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [TAP_CFG_W-1:0] r_tap_count;
    logic [DEC_CFG_W-1:0] r_decim;
    logic [CNT_W-1:0]     r_seen, n_seen;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [TAP_AW-1:0]    r_flush, n_flush;
    logic [TAP_AW-1:0]    r_k, n_k;
    logic [RES_W-1:0]     r_res, n_res;
    logic                 r_last, n_last;
    logic                 r_have_pend, n_have_pend;

    logic [TC_W-1:0]      w_tc;
    logic [CNT_W-1:0]     w_m;
    logic [DEC_CFG_W-1:0] w_d;
    logic [CNT_W-1:0]     a_seen;
    logic [PHASE_W-1:0]   a_ph;
    logic [DEC_CFG_W-1:0] a_ph_inc;
    logic [PHASE_W-1:0]   a_phase;
    logic                 a_emit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_decim     <= DECIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAP_CFG_W-1:0];
                CFG_DECIM:     r_decim     <= i_cfg_data[DEC_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective tap count and decimation factor
    always_comb begin
        w_tc = TC_W'(r_tap_count);
        if (w_tc == '0) begin
            w_m = CNT_W'(1);
        end else if (w_tc > TC_W'(MAX_TAPS)) begin
            w_m = CNT_W'(MAX_TAPS);
        end else begin
            w_m = CNT_W'(w_tc);
        end
        if (r_decim == '0) begin
            w_d = DEC_CFG_W'(1);
        end else if (r_decim > DEC_MAX) begin
            w_d = DEC_MAX;
        end else begin
            w_d = r_decim;
        end
    end

    // one step of the delay line: sample count, decimation phase, keep decision
    always_comb begin
        a_seen   = (r_seen < w_m) ? r_seen + CNT_W'(1) : r_seen;
        a_ph     = (DEC_CFG_W'(r_phase) >= w_d) ? '0 : r_phase;
        a_ph_inc = DEC_CFG_W'(a_ph) + DEC_CFG_W'(1);
        a_phase  = r_phase;
        a_emit   = 1'b0;
        if (a_seen >= w_m) begin
            a_emit  = (a_ph == '0) && (r_res < RES_W'(RES_LIMIT));
            a_phase = (a_ph_inc >= w_d) ? '0 : PHASE_W'(a_ph_inc);
        end
    end

    assign o_tap = r_k;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_phase     = r_phase;
        n_flush     = r_flush;
        n_k         = r_k;
        n_res       = r_res;
        n_last      = r_last;
        n_have_pend = r_have_pend;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == KIND_COEF) begin
                        o_cmd.coef_we = 1'b1;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_seen    = a_seen;
                        n_phase   = a_phase;
                        n_last    = i_in_frame_end;
                        n_flush   = i_in_frame_end ? TAP_AW'(w_m - CNT_W'(1)) : '0;
                        if (a_emit) begin
                            o_cmd.acc_clr = 1'b1;
                            n_k           = '0;
                            n_res         = r_res + RES_W'(1);
                            n_state       = S_MAC;
                        end else if (i_in_frame_end) begin
                            n_state = (n_flush != '0) ? S_ADV : S_FIN;
                        end
                    end
                end
            end
            S_ADV: begin
                // zero sample of the convolution tail
                o_cmd.adv      = 1'b1;
                o_cmd.adv_zero = 1'b1;
                n_flush        = r_flush - TAP_AW'(1);
                n_seen         = a_seen;
                n_phase        = a_phase;
                if (a_emit) begin
                    o_cmd.acc_clr = 1'b1;
                    n_k           = '0;
                    n_res         = r_res + RES_W'(1);
                    n_state       = S_MAC;
                end else begin
                    n_state = (n_flush != '0) ? S_ADV : S_FIN;
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if (CNT_W'(r_k) == w_m - CNT_W'(1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + TAP_AW'(1);
                end
            end
            S_WAIT: begin
                // older result leaves for the output register as the new one is rounded
                if (!i_status.pipe_busy && (!r_have_pend || i_status.out_free)) begin
                    o_cmd.round = 1'b1;
                    o_cmd.push  = r_have_pend;
                    n_have_pend = 1'b1;
                    n_state     = (r_flush != '0) ? S_ADV : S_FIN;
                end
            end
            S_FIN: begin
                if (!r_have_pend || i_status.out_free) begin
                    o_cmd.push      = r_have_pend;
                    o_cmd.push_last = r_last;
                    n_have_pend     = 1'b0;
                    n_res           = '0;
                    n_last          = 1'b0;
                    if (r_last) begin
                        n_seen          = '0;
                        n_phase         = '0;
                        o_cmd.frame_clr = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_phase     <= '0;
            r_flush     <= '0;
            r_k         <= '0;
            r_res       <= '0;
            r_last      <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_phase     <= n_phase;
            r_flush     <= n_flush;
            r_k         <= n_k;
            r_res       <= n_res;
            r_last      <= n_last;
            r_have_pend <= n_have_pend;
        end
    end

endmodule

// ----- sv/mfd_dp.sv -----
module mfd_dp #(
    parameter int MAX_TAPS = 128,
    parameter int TAP_AW   = 7
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mfd_pkg::t_dp_cmd                       i_cmd,
    input  logic [TAP_AW-1:0]                      i_tap,
    input  logic signed [mfd_pkg::SAMPLE_W-1:0]    i_sample_i,
    input  logic signed [mfd_pkg::SAMPLE_W-1:0]    i_sample_q,
    input  logic [mfd_pkg::COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [mfd_pkg::COEF_W-1:0]      i_coef_value,
    output mfd_pkg::t_dp_status                    o_status,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [mfd_pkg::SAMPLE_W-1:0]    o_out_i,
    output logic signed [mfd_pkg::SAMPLE_W-1:0]    o_out_q,
    output logic                                   o_clipped,
    output logic                                   o_last_of_run
);
    import mfd_pkg::*;

    localparam int WORD_W = 2 * SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + TAP_AW;
    localparam int QW     = ACC_W - ROUND_SHIFT;
    localparam int DW     = TAP_AW + 2;
    localparam int CI_XW  = ((TAP_AW > COEF_IDX_W) ? TAP_AW : COEF_IDX_W) + 1;
    localparam logic signed [QW-1:0] Q_MAX = QW'(SAT_HI);
    localparam logic signed [QW-1:0] Q_MIN = QW'(SAT_LO);

    logic [WORD_W-1:0]          r_dly_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   r_coef_mem [MAX_TAPS];
    logic [TAP_AW-1:0]          r_wp;
    logic [CI_XW-1:0]           w_ci;
    logic                       w_ci_ok;
    logic [WORD_W-1:0]          w_wr_word;
    logic [DW-1:0]              w_diff;
    logic [TAP_AW-1:0]          w_rd_addr;

    logic signed [COEF_W-1:0]   r_coef_rd;
    logic [WORD_W-1:0]          r_dly_rd;
    logic signed [SAMPLE_W-1:0] w_dly_i;
    logic signed [SAMPLE_W-1:0] w_dly_q;
    logic                       r_v1, r_v2;
    logic signed [PROD_W-1:0]   r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0]    r_acc_i, r_acc_q;
    logic [SAMPLE_W:0]          w_rnd_i, w_rnd_q;

    logic signed [SAMPLE_W-1:0] r_pend_i, r_pend_q;
    logic                       r_pend_clip;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_i, r_out_q;
    logic                       r_out_clip, r_out_last;

    // round to nearest by the fraction shift, saturate, flag in the top bit
    function automatic logic [SAMPLE_W:0] f_round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rs;
        logic signed [QW-1:0]    q;
        logic [SAMPLE_W:0]       res;
        rs = acc + ACC_W'(ROUND_HALF);
        q  = rs[ACC_W-1:ROUND_SHIFT];
        if (q > Q_MAX) begin
            res = {1'b1, SAT_HI};
        end else if (q < Q_MIN) begin
            res = {1'b1, SAT_LO};
        end else begin
            res = {1'b0, q[SAMPLE_W-1:0]};
        end
        return res;
    endfunction

    // coefficient store, writes beyond the store are dropped
    assign w_ci    = CI_XW'(i_coef_index);
    assign w_ci_ok = (w_ci < CI_XW'(MAX_TAPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_we && w_ci_ok) begin
            r_coef_mem[w_ci[TAP_AW-1:0]] <= i_coef_value;
        end
    end

    // delay line write, q in the upper half
    assign w_wr_word = i_cmd.adv_zero ? '0 : {i_sample_q, i_sample_i};

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            r_dly_mem[r_wp] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.frame_clr) begin
            r_wp <= '0;
        end else if (i_cmd.adv) begin
            r_wp <= (r_wp == TAP_AW'(MAX_TAPS - 1)) ? '0 : r_wp + TAP_AW'(1);
        end
    end

    // tap k reads the sample written k steps before the newest one
    always_comb begin
        w_diff = {2'b00, r_wp} - {2'b00, i_tap} - DW'(1);
        if (w_diff[DW-1]) begin
            w_rd_addr = TAP_AW'(w_diff + DW'(MAX_TAPS));
        end else begin
            w_rd_addr = w_diff[TAP_AW-1:0];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_coef_rd <= r_coef_mem[i_tap];
            r_dly_rd  <= r_dly_mem[w_rd_addr];
        end
    end

    assign w_dly_i = r_dly_rd[SAMPLE_W-1:0];
    assign w_dly_q = r_dly_rd[WORD_W-1:SAMPLE_W];

    // multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod_i <= r_coef_rd * w_dly_i;
            r_prod_q <= r_coef_rd * w_dly_q;
        end
        if (i_cmd.acc_clr) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_v2) begin
            r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
        end
    end

    // rounding into the pending result
    assign w_rnd_i = f_round_sat(r_acc_i);
    assign w_rnd_q = f_round_sat(r_acc_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_pend_i    <= w_rnd_i[SAMPLE_W-1:0];
            r_pend_q    <= w_rnd_q[SAMPLE_W-1:0];
            r_pend_clip <= w_rnd_i[SAMPLE_W] | w_rnd_q[SAMPLE_W];
        end
    end

    // output register, freed by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_i    <= r_pend_i;
            r_out_q    <= r_pend_q;
            r_out_clip <= r_pend_clip;
            r_out_last <= i_cmd.push_last;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_i       = r_out_i;
    assign o_out_q       = r_out_q;
    assign o_clipped     = r_out_clip;
    assign o_last_of_run = r_out_last;

endmodule

// ----- sv/matched_filter_decimator.sv -----
// coefficient write or sample with no kept output and no frame end: next item taken at once
// sample with a kept output: the single shared i/q multiply-accumulate takes one tap per cycle;
// the result leaves as the item ends
// frame end adds tap_count - 1 zero steps, each with its own keep decision
// the default setup is 33 taps, decimation 4
// reset (synchronous, active low) clears control state only; coefficients stay unknown
module matched_filter_decimator #(
    parameter int MAX_TAPS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mfd_in_if.sink                            i_in,
    mfd_out_if.source                         o_out
);
    import mfd_pkg::*;

    localparam int TAP_AW = $clog2(MAX_TAPS);

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [TAP_AW-1:0] w_tap;
    logic              w_in_ready;
    logic              w_out_valid;

    // sequencer
    mfd_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .TAP_AW   (TAP_AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in.valid),
        .i_in_kind      (i_in.kind),
        .i_in_frame_end (i_in.frame_end),
        .o_in_ready     (w_in_ready),
        .o_cmd          (w_cmd),
        .o_tap          (w_tap),
        .i_status       (w_status)
    );

    // memories, multiply-accumulate and output register
    mfd_dp #(
        .MAX_TAPS (MAX_TAPS),
        .TAP_AW   (TAP_AW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_tap         (w_tap),
        .i_sample_i    (i_in.sample_i),
        .i_sample_q    (i_in.sample_q),
        .i_coef_index  (i_in.coef_index),
        .i_coef_value  (i_in.coef_value),
        .o_status      (w_status),
        .o_out_valid   (w_out_valid),
        .i_out_ready   (o_out.ready),
        .o_out_i       (o_out.out_i),
        .o_out_q       (o_out.out_q),
        .o_clipped     (o_out.clipped),
        .o_last_of_run (o_out.last_of_run)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // new items only once the multiply-accumulate pipe has drained
    a_ready_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_status.pipe_busy)
        else $error("input ready while the mac pipe is busy");

    // a result only moves into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_status.out_free)
        else $error("result pushed over an untaken result");

    // rounding only once every product is in the accumulator
    a_round_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.round |-> !w_status.pipe_busy && !w_cmd.issue)
        else $error("rounding before the accumulation has finished");

    // a pushed result is shown on the next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_out.valid)
        else $error("pushed result not presented");

endmodule

// ----- tb/matched_filter_decimator_tb.sv -----
`timescale 1ns / 1ps

module matched_filter_decimator_tb;
    import mfd_pkg::*;

    localparam int FILTER_DEPTH = 128;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam longint LIMIT_NS = 40_000_000;

    // one input transfer
    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
        logic                       frame_end;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } t_stim;

    // one filtered, decimated output
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       clip;
        logic                       last;
    } t_filt_res;

    typedef struct {
        t_stim     item;
        bit        typed;
        t_filt_res res;
    } t_dir_row;

    localparam t_filt_res NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mfd_in_if  in_bus ();
    mfd_out_if out_bus ();

    matched_filter_decimator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // filter model state
    logic signed [COEF_W-1:0]   coef_mem [FILTER_DEPTH];
    logic signed [SAMPLE_W-1:0] line_i [FILTER_DEPTH];
    logic signed [SAMPLE_W-1:0] line_q [FILTER_DEPTH];
    int unsigned                wr_ptr;
    int unsigned                seen;
    int unsigned                phase;
    logic [TAP_CFG_W-1:0]       taps_reg;
    logic [DEC_CFG_W-1:0]       decim_reg;

    t_filt_res step_res [$];
    t_filt_res expected_q [$];
    t_dir_row  dir_rows [$];

    int errors;
    int src_idle_pct;
    int sink_stall_pct;

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned taps_in_use();
        if (taps_reg == 0) return 1;
        if (taps_reg > FILTER_DEPTH) return FILTER_DEPTH;
        return taps_reg;
    endfunction

    function automatic int unsigned decim_in_use();
        if (decim_reg == 0) return 1;
        if (decim_reg > DEC_MAX) return DEC_MAX;
        return decim_reg;
    endfunction

    // round half up by 14 bits, saturate to q1.15; bit 16 flags saturation
    function automatic logic [SAMPLE_W:0] to_q15(input longint acc);
        longint v;
        v = (acc + ROUND_HALF) >>> ROUND_SHIFT;
        if (v > longint'(SAT_HI)) return {1'b1, SAT_HI};
        if (v < longint'(SAT_LO)) return {1'b1, SAT_LO};
        return {1'b0, v[SAMPLE_W-1:0]};
    endfunction

    // push one sample into the delay line and form the output if it is kept
    task automatic shift_in(input logic signed [SAMPLE_W-1:0] si,
                            input logic signed [SAMPLE_W-1:0] sq);
        int unsigned m;
        int unsigned d;
        int unsigned k;
        int unsigned slot;
        longint      acc_i;
        longint      acc_q;
        logic [SAMPLE_W:0] ri;
        logic [SAMPLE_W:0] rq;
        t_filt_res   r;
        m = taps_in_use();
        d = decim_in_use();
        line_i[wr_ptr] = si;
        line_q[wr_ptr] = sq;
        wr_ptr = (wr_ptr + 1) % FILTER_DEPTH;
        if (seen < m) seen++;
        if (seen >= m) begin
            if (phase >= d) phase = 0;
            if (phase == 0 && step_res.size() < RES_LIMIT) begin
                acc_i = 0;
                acc_q = 0;
                for (k = 0; k < m; k++) begin
                    slot = (wr_ptr + FILTER_DEPTH - 1 - k) % FILTER_DEPTH;
                    acc_i += longint'(coef_mem[k]) * longint'(line_i[slot]);
                    acc_q += longint'(coef_mem[k]) * longint'(line_q[slot]);
                end
                ri = to_q15(acc_i);
                rq = to_q15(acc_q);
                r.re = ri[SAMPLE_W-1:0];
                r.im = rq[SAMPLE_W-1:0];
                r.clip = ri[SAMPLE_W] | rq[SAMPLE_W];
                r.last = 1'b0;
                step_res.insert(step_res.size(), r);
            end
            phase = (phase + 1 >= d) ? 0 : phase + 1;
        end
    endtask

    // results caused by one accepted transfer land in step_res
    task automatic filter_step(input t_stim s);
        int unsigned t;
        int unsigned m;
        step_res.delete();
        if (s.kind == KIND_COEF) begin
            coef_mem[s.coef_index] = s.coef_value;
            return;
        end
        shift_in(s.sample_i, s.sample_q);
        if (s.frame_end) begin
            m = taps_in_use();
            for (t = 1; t < m; t++) shift_in('0, '0);
            if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
            for (t = 0; t < FILTER_DEPTH; t++) begin
                line_i[t] = '0;
                line_q[t] = '0;
            end
            wr_ptr = 0;
            seen = 0;
            phase = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic logic [15:0] pick_word();
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic t_stim make_sample(input logic fe);
        t_stim s;
        s.kind = KIND_SAMPLE;
        s.sample_i = pick_word();
        s.sample_q = pick_word();
        s.frame_end = fe;
        s.coef_index = 7'($urandom);
        s.coef_value = 16'($urandom);
        return s;
    endfunction

    // mostly small taps so that sums stay in range, now and then the full span
    function automatic t_stim make_coef(input logic [COEF_IDX_W-1:0] idx);
        t_stim s;
        s.kind = KIND_COEF;
        s.sample_i = 16'($urandom);
        s.sample_q = 16'($urandom);
        s.frame_end = 1'($urandom);
        s.coef_index = idx;
        if ($urandom_range(99) < 20) s.coef_value = pick_word();
        else s.coef_value = 16'($urandom_range(4095)) - 16'd2048;
        return s;
    endfunction

    // one input transfer, with random sender gaps ahead of it
    task automatic send_item(input t_stim s);
        int gap;
        gap = 0;
        if (src_idle_pct > 0) begin
            while ($urandom_range(99) < src_idle_pct) gap++;
        end
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.kind       <= s.kind;
        in_bus.sample_i   <= s.sample_i;
        in_bus.sample_q   <= s.sample_q;
        in_bus.frame_end  <= s.frame_end;
        in_bus.coef_index <= s.coef_index;
        in_bus.coef_value <= s.coef_value;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    task automatic apply_item(input t_stim s);
        send_item(s);
        filter_step(s);
        foreach (step_res[idx]) expected_q.insert(expected_q.size(), step_res[idx]);
    endtask

    task automatic table_add(input t_stim item, input bit typed, input t_filt_res res);
        t_dir_row row;
        row.item = item;
        row.typed = typed;
        row.res = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // drain all results, then let a long tail finish before touching registers
    task automatic settle();
        int unsigned m;
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
        m = taps_in_use();
        repeat (m * (m + 6) + 32) @(posedge clk);
    endtask

    // one block of random frames under a given register setting and idling mix
    task automatic run_phase(input logic [CFG_DATA_W-1:0] tap_data,
                             input logic [CFG_DATA_W-1:0] dec_data,
                             input int src_idle, input int sink_stall, input int n_items,
                             input bit pause, input bit spare, input bit leave_open);
        int sent;
        int len;
        int j;
        bit closes;
        bit held;
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TAP_COUNT;
        cfg_data <= tap_data;
        @(posedge clk);
        cfg_idx  <= CFG_DECIM;
        cfg_data <= dec_data;
        @(posedge clk);
        if (spare) begin
            cfg_idx  <= CFG_SPARE_A;
            cfg_data <= CFG_DATA_W'($urandom);
            @(posedge clk);
            cfg_idx  <= CFG_SPARE_B;
            cfg_data <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        taps_reg = tap_data;
        decim_reg = dec_data[DEC_CFG_W-1:0];
        src_idle_pct = src_idle;
        sink_stall_pct = sink_stall;

        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            // hold the sender once until the output side has caught up
            if (pause && !held && sent >= n_items / 2) begin
                in_bus.valid <= 1'b0;
                do @(posedge clk); while (expected_q.size() != 0);
                held = 1'b1;
            end
            if ($urandom_range(99) < 10) begin
                apply_item(make_coef(7'($urandom_range(127))));
                sent++;
            end else begin
                if ($urandom_range(7) == 0) len = $urandom_range(taps_in_use() + 8, 1);
                else len = $urandom_range(16, 1);
                // keep the block near its item budget
                if (len > n_items - sent) len = n_items - sent;
                // now and then a frame is left without its end marker
                closes = ($urandom_range(9) != 0);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(99) < 6) begin
                        apply_item(make_coef(7'($urandom_range(127))));
                        sent++;
                    end
                    apply_item(make_sample(closes && j == len - 1));
                    sent++;
                end
            end
        end
        // frame still open when the registers change
        if (leave_open) begin
            repeat (4) apply_item(make_sample(1'b0));
        end
    endtask

    // output side: random stalls
    always @(posedge clk) begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk) begin
        t_filt_res want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h %h", out_bus.out_i,
                                          out_bus.out_q));
            end else begin
                want = expected_q.pop_front();
                if (out_bus.out_i !== want.re)
                    report_mismatch($sformatf("out_i %h, want %h", out_bus.out_i, want.re));
                if (out_bus.out_q !== want.im)
                    report_mismatch($sformatf("out_q %h, want %h", out_bus.out_q, want.im));
                if (out_bus.clipped !== want.clip)
                    report_mismatch($sformatf("clipped %b, want %b", out_bus.clipped,
                                              want.clip));
                if (out_bus.last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              out_bus.last_of_run, want.last));
            end
        end
    end

    // main sequence
    initial begin
        int k;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_TAP_COUNT;
        cfg_data          <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.kind       <= KIND_SAMPLE;
        in_bus.sample_i   <= '0;
        in_bus.sample_q   <= '0;
        in_bus.frame_end  <= 1'b0;
        in_bus.coef_index <= '0;
        in_bus.coef_value <= '0;
        errors = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        for (k = 0; k < FILTER_DEPTH; k++) begin
            coef_mem[k] = '0;
            line_i[k] = '0;
            line_q[k] = '0;
        end
        wr_ptr = 0;
        seen = 0;
        phase = 0;
        taps_reg = TAP_COUNT_RST;
        decim_reg = DECIM_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // load every coefficient slot before any sample reads one
        for (k = 0; k < FILTER_DEPTH; k++) apply_item(make_coef(7'(k)));

        // directed rows at reset setup (33 taps, keep every 4th); a lone sample in a
        // frame gives exactly one output, tap 32 times the sample
        table_add('{KIND_COEF, 16'sh7FFF, 16'sh8000, 1'b1, 7'd32, 16'sh4000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b1, 7'd0, 16'sh0000}, 1,
                  '{16'sh7FFF, 16'sh8000, 1'b0, 1'b1});
        table_add('{KIND_COEF, 16'sh0000, 16'sh0000, 1'b0, 7'd32, 16'sh8000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b1, 7'd127, 16'sh7FFF}, 1,
                  '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1});
        table_add('{KIND_COEF, 16'shFFFF, 16'shFFFF, 1'b0, 7'd32, 16'sh7FFF}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh7FFF, 16'sh0000, 1'b1, 7'd0, 16'sh0000}, 1,
                  '{16'sh7FFF, 16'sh0000, 1'b1, 1'b1});
        table_add('{KIND_COEF, 16'sh0000, 16'sh0000, 1'b1, 7'd32, 16'sh0001}, 0, NO_RESULT);
        // rounding at exactly one half, upwards on both signs, then just off one half
        table_add('{KIND_SAMPLE, 16'sh2000, 16'shE000, 1'b1, 7'd0, 16'sh0000}, 1,
                  '{16'sh0001, 16'sh0000, 1'b0, 1'b1});
        table_add('{KIND_SAMPLE, 16'shDFFF, 16'sh1FFF, 1'b1, 7'd0, 16'sh0000}, 1,
                  '{16'shFFFF, 16'sh0000, 1'b0, 1'b1});
        table_add('{KIND_COEF, 16'sh1234, 16'sh4321, 1'b1, 7'd0, 16'sh4000}, 0, NO_RESULT);
        table_add('{KIND_COEF, 16'sh0000, 16'sh0000, 1'b0, 7'd127, 16'shFFFF}, 0, NO_RESULT);
        // short frame, tail and decimation from the model
        table_add('{KIND_SAMPLE, 16'sh04D2, 16'shFC19, 1'b0, 7'd0, 16'sh0000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b0, 7'd0, 16'sh0000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh8000, 16'sh8000, 1'b0, 7'd0, 16'sh0000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh0100, 16'shFF00, 1'b0, 7'd0, 16'sh0000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh3000, 16'shD000, 1'b1, 7'd0, 16'sh0000}, 0, NO_RESULT);
        table_add('{KIND_SAMPLE, 16'sh0000, 16'sh0000, 1'b1, 7'd0, 16'sh0000}, 1,
                  '{16'sh0000, 16'sh0000, 1'b0, 1'b1});

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item);
            filter_step(dir_rows[r].item);
            if (dir_rows[r].typed) expected_q.insert(expected_q.size(), dir_rows[r].res);
            else foreach (step_res[idx]) expected_q.insert(expected_q.size(), step_res[idx]);
        end

        // random frames over a spread of settings and idling mixes
        run_phase(8'd33,  8'h04, 0,  0,  40, 1, 0, 0);
        run_phase(8'd1,   8'h01, 75, 0,  25, 0, 0, 0);
        run_phase(8'd20,  8'hF1, 0,  75, 25, 0, 0, 0);
        run_phase(8'd12,  8'h03, 24, 24, 25, 0, 1, 1);
        run_phase(8'd128, 8'h02, 0,  0,  14, 0, 0, 0);
        run_phase(8'd0,   8'h00, 24, 24, 25, 1, 0, 0);
        run_phase(8'd200, 8'h0F, 75, 0,  12, 0, 0, 1);
        run_phase(8'd7,   8'h08, 0,  75, 25, 0, 0, 0);
        run_phase(8'd45,  8'hA6, 24, 24, 25, 0, 0, 0);

        settle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- matched_filter_decimator.f -----
sv/mfd_pkg.sv
sv/mfd_in_if.sv
sv/mfd_out_if.sv
sv/mfd_ctrl.sv
sv/mfd_dp.sv
sv/matched_filter_decimator.sv
tb/matched_filter_decimator_tb.sv
